[design/tod_pkg.sv]
// ----------------------------------------------------------------------------
// Time-of-day clock package
// Item kinds, status codes, time limits and the small digit helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tod_pkg;

  // item kinds
  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_SYNC = 2'd1,
    KIND_SET  = 2'd2
  } kind_e;

  // reported sync status
  typedef enum logic [1:0] {
    STATUS_SYNCED   = 2'd0,
    STATUS_STALE    = 2'd1,
    STATUS_FREE_RUN = 2'd2
  } status_e;

  localparam logic [4:0]  HOUR_LAST   = 5'd23;
  localparam logic [5:0]  MINUTE_LAST = 6'd59;
  localparam logic [5:0]  SECOND_LAST = 6'd59;
  localparam logic [31:0] HOLD_RESET  = 32'd10;
  localparam logic [7:0]  ASCII_ZERO  = 8'h30;
  localparam logic [7:0]  ASCII_COLON = 8'h3a;
  // '0' * 11 folded modulo 256, negated
  localparam logic [7:0]  PAIR_BIAS   = 8'd240;

  // two ascii characters to a value modulo 256
  function automatic logic [7:0] decode_pair(input logic [7:0] hi, input logic [7:0] lo);
    decode_pair = {hi[4:0], 3'b000} + {hi[6:0], 1'b0} + lo + PAIR_BIAS;
  endfunction

  // 8-bit value modulo 24 by binary restoring steps
  function automatic logic [4:0] mod24(input logic [7:0] x);
    logic [7:0] r;
    r = x;
    if (r >= 8'd192) r = r - 8'd192;
    if (r >= 8'd96)  r = r - 8'd96;
    if (r >= 8'd48)  r = r - 8'd48;
    if (r >= 8'd24)  r = r - 8'd24;
    mod24 = r[4:0];
  endfunction

  // 8-bit value modulo 60 by binary restoring steps
  function automatic logic [5:0] mod60(input logic [7:0] x);
    logic [7:0] r;
    r = x;
    if (r >= 8'd240) r = r - 8'd240;
    if (r >= 8'd120) r = r - 8'd120;
    if (r >= 8'd60)  r = r - 8'd60;
    mod60 = r[5:0];
  endfunction

  // value below 60 to two ascii digits, tens in the low byte
  function automatic logic [15:0] two_digits(input logic [5:0] v);
    logic [5:0] r;
    logic [2:0] tens;
    r    = v;
    tens = 3'd0;
    if (r >= 6'd40) begin
      r    = r - 6'd40;
      tens = tens + 3'd4;
    end
    if (r >= 6'd20) begin
      r    = r - 6'd20;
      tens = tens + 3'd2;
    end
    if (r >= 6'd10) begin
      r    = r - 6'd10;
      tens = tens + 3'd1;
    end
    two_digits = {ASCII_ZERO + {4'd0, r[3:0]}, ASCII_ZERO + {5'd0, tens}};
  endfunction

endpackage

`default_nettype wire

[design/time_of_day_clock_with_sync_status.sv]
// ----------------------------------------------------------------------------
// Time-of-day clock with sync status
// 24-hour hh:mm:ss clock with tick, text sync and direct set requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request: a one-second
//   tick, a sync from ascii HH:MM:SS or HHMMSS text, or a direct set. Every
//   request gives exactly one result on the output channel (out_valid_o /
//   out_stall_i) with the time after it, the sync status, the age since the
//   last sync and the time as ascii text.
//   The cfg channel writes the sync hold threshold; it is always ready and
//   should only be written while no request is in flight.
//   A request taken lands in the input register, its result is then
//   registered in the result register and taken from there by the receiver.
//   Throughput: one request per cycle; the clock state is updated by one
//   pass of logic between the input register and the result register.
//   When the receiver stalls, the result register holds, the input register
//   fills behind it, and then in_stall_o rises.
//   Reset clears the time to 00:00:00, the age to zero, the status to free
//   running and the hold threshold to ten seconds.
// ----------------------------------------------------------------------------
`default_nettype none

module time_of_day_clock_with_sync_status #(
  parameter int AGE_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [63:0] text_chars_i,
  input  wire logic        colon_format_i,
  input  wire logic [7:0]  set_hours_i,
  input  wire logic [7:0]  set_minutes_i,
  input  wire logic [7:0]  set_seconds_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [4:0]       hours_now_o,
  output logic [5:0]       minutes_now_o,
  output logic [5:0]       seconds_now_o,
  output logic [1:0]       sync_status_o,
  output logic [31:0]      age_seconds_o,
  output logic [63:0]      time_text_o,
  // hold threshold write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i
);

  localparam int CMP_WIDTH = (AGE_WIDTH > 32) ? AGE_WIDTH : 32;

  // input register
  logic        s1_valid_q, s1_valid_d;
  logic [1:0]  kind_q;
  logic [63:0] text_q;
  logic        colon_q;
  logic [7:0]  set_h_q, set_m_q, set_s_q;

  // clock state
  logic [4:0]           hour_q, hour_d;
  logic [5:0]           minute_q, minute_d;
  logic [5:0]           second_q, second_d;
  logic                 synced_q, synced_d;
  logic [AGE_WIDTH-1:0] age_q, age_d;
  logic [31:0]          hold_q;

  // result register
  logic        out_valid_q, out_valid_d;
  logic [4:0]  res_h_q;
  logic [5:0]  res_m_q, res_s_q;
  logic [1:0]  res_status_q, res_status_d;
  logic [31:0] res_age_q;
  logic [63:0] res_text_q, res_text_d;

  logic in_accept, s1_advance, s1_fire;
  logic [7:0] pair_h, pair_m, pair_s;
  logic [15:0] txt_h, txt_m, txt_s;

  // handshake
  assign s1_advance = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign s1_fire    = s1_valid_q && s1_advance;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // sync text pairs, colon form skips one character between pairs
  assign pair_h = tod_pkg::decode_pair(text_q[7:0], text_q[15:8]);
  assign pair_m = colon_q ? tod_pkg::decode_pair(text_q[31:24], text_q[39:32])
                          : tod_pkg::decode_pair(text_q[23:16], text_q[31:24]);
  assign pair_s = colon_q ? tod_pkg::decode_pair(text_q[55:48], text_q[63:56])
                          : tod_pkg::decode_pair(text_q[39:32], text_q[47:40]);

  // next clock state
  always_comb begin
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    synced_d = synced_q;
    age_d    = age_q;
    case (tod_pkg::kind_e'(kind_q))
      tod_pkg::KIND_TICK: begin
        if (second_q == tod_pkg::SECOND_LAST) begin
          second_d = 6'd0;
          if (minute_q == tod_pkg::MINUTE_LAST) begin
            minute_d = 6'd0;
            hour_d   = (hour_q == tod_pkg::HOUR_LAST) ? 5'd0 : hour_q + 5'd1;
          end else begin
            minute_d = minute_q + 6'd1;
          end
        end else begin
          second_d = second_q + 6'd1;
        end
        if (age_q != {AGE_WIDTH{1'b1}}) begin
          age_d = age_q + {{(AGE_WIDTH-1){1'b0}}, 1'b1};
        end
      end
      tod_pkg::KIND_SYNC: begin
        hour_d   = (pair_h > {3'd0, tod_pkg::HOUR_LAST})   ? 5'd0 : pair_h[4:0];
        minute_d = (pair_m > {2'd0, tod_pkg::MINUTE_LAST}) ? 6'd0 : pair_m[5:0];
        second_d = (pair_s > {2'd0, tod_pkg::SECOND_LAST}) ? 6'd0 : pair_s[5:0];
        synced_d = 1'b1;
        age_d    = '0;
      end
      tod_pkg::KIND_SET: begin
        hour_d   = tod_pkg::mod24(set_h_q);
        minute_d = tod_pkg::mod60(set_m_q);
        second_d = tod_pkg::mod60(set_s_q);
      end
      default: begin
      end
    endcase
  end

  // status and text of the new state
  always_comb begin
    if (!synced_d) begin
      res_status_d = tod_pkg::STATUS_FREE_RUN;
    end else if (CMP_WIDTH'(age_d) <= CMP_WIDTH'(hold_q)) begin
      res_status_d = tod_pkg::STATUS_SYNCED;
    end else begin
      res_status_d = tod_pkg::STATUS_STALE;
    end
  end

  assign txt_h = tod_pkg::two_digits({1'b0, hour_d});
  assign txt_m = tod_pkg::two_digits(minute_d);
  assign txt_s = tod_pkg::two_digits(second_d);
  assign res_text_d = {txt_s, tod_pkg::ASCII_COLON, txt_m, tod_pkg::ASCII_COLON, txt_h};

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hour_q      <= '0;
      minute_q    <= '0;
      second_q    <= '0;
      synced_q    <= 1'b0;
      age_q       <= '0;
      hold_q      <= tod_pkg::HOLD_RESET;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        hour_q   <= hour_d;
        minute_q <= minute_d;
        second_q <= second_d;
        synced_q <= synced_d;
        age_q    <= age_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        hold_q <= cfg_data_i;
      end
    end
  end

  // input payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q  <= kind_i;
      text_q  <= text_chars_i;
      colon_q <= colon_format_i;
      set_h_q <= set_hours_i;
      set_m_q <= set_minutes_i;
      set_s_q <= set_seconds_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_h_q      <= hour_d;
      res_m_q      <= minute_d;
      res_s_q      <= second_d;
      res_status_q <= res_status_d;
      res_age_q    <= 32'(age_d);
      res_text_q   <= res_text_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hours_now_o   = res_h_q;
  assign minutes_now_o = res_m_q;
  assign seconds_now_o = res_s_q;
  assign sync_status_o = res_status_q;
  assign age_seconds_o = res_age_q;
  assign time_text_o   = res_text_q;

  // the input side only stalls with a request held in the input register
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  // a sync request never reports free running
  a_sync_sets_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && kind_q == tod_pkg::KIND_SYNC) |=>
      (sync_status_o == tod_pkg::STATUS_SYNCED || sync_status_o == tod_pkg::STATUS_STALE))
    else $error("sync request reported free running");

  // results always hold a legal time
  a_time_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hours_now_o <= tod_pkg::HOUR_LAST &&
                     minutes_now_o <= tod_pkg::MINUTE_LAST &&
                     seconds_now_o <= tod_pkg::SECOND_LAST))
    else $error("time out of range");

  // a stalled result stays valid and its text does not change
  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(res_text_q)))
    else $error("stalled result changed");

endmodule

`default_nettype wire
